// ===== hdl/unbounded_knapsack_min_cost_macros.svh =====
// ----------------------------------------------------------------------------
// unbounded_knapsack_min_cost assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef UNBOUNDED_KNAPSACK_MIN_COST_MACROS_SVH
`define UNBOUNDED_KNAPSACK_MIN_COST_MACROS_SVH

// property must hold at every clock edge outside reset
`define UKMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define UKMC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/ukmc_pkg.sv =====
// ----------------------------------------------------------------------------
// ukmc_pkg
// shared types and constants of the minimum cost knapsack table
// ----------------------------------------------------------------------------
package ukmc_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CostW      = 24;
  localparam int unsigned ItemCostW  = 16;
  localparam int unsigned GainW      = 10;
  localparam int unsigned TargetW    = 10;

  localparam logic [CostW-1:0] Unreachable = 24'd10000000;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_QUERY = 4'b1000
  } state_e;

endpackage

// ===== hdl/unbounded_knapsack_min_cost.sv =====
// ----------------------------------------------------------------------------
// unbounded_knapsack_min_cost
// table of minimum cost to reach at least each target, items of unlimited supply
// query: result strobes in the cycle after the request is taken, busy high for a single cycle
// add: one table entry relaxed per cycle (two-read-port ram)
// clear: one entry written per cycle
// reset: clearing pass over all TableDepth (1024) entries, busy high until done
// max_target resets to 1023; results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module unbounded_knapsack_min_cost
  import ukmc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode_i,
  input  logic [ItemCostW-1:0] item_cost_i,
  input  logic [GainW-1:0]     item_gain_i,
  input  logic [TargetW-1:0]   query_index_i,
  output logic [CostW-1:0]     min_cost_o,
  output logic                 min_cost_valid_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [TargetW-1:0]   cfg_data_i
);

  state_e               state_q, state_d;
  logic [AddrW-1:0]     cnt_q, cnt_d;
  logic [TargetW-1:0]   max_target_q;
  logic [AddrW-1:0]     top_q, top_d;
  logic [ItemCostW-1:0] cost_q, cost_d;
  logic [GainW-1:0]     gain_q, gain_d;
  logic                 qry_oor_q, qry_oor_d;

  logic                 s1_valid_q, s1_valid_d;
  logic [AddrW-1:0]     s1_t_q, s1_t_d;
  logic                 s1_low_q, s1_low_d;
  logic                 fwd_q, fwd_d;
  logic [CostW-1:0]     fwd_data_q;

  logic                 accept;
  logic [AddrW-1:0]     top_calc;
  logic [AddrW-1:0]     raddr_a, raddr_b;
  logic [CostW-1:0]     rdata_a, rdata_b;
  logic [CostW-1:0]     low_val;
  logic [CostW:0]       sum;
  logic [CostW-1:0]     cand;
  logic                 upd_we;
  logic                 we;
  logic [AddrW-1:0]     waddr;
  logic [CostW-1:0]     wdata;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE) || s1_valid_q;
  assign cfg_ready_o = 1'b1;

  assign top_calc = (32'(max_target_q) >= TableDepth) ? AddrW'(TableDepth - 1)
                                                      : AddrW'(max_target_q);

  // relax step: entry one gain lower, forwarded when written in the previous cycle
  assign low_val = fwd_q ? fwd_data_q : rdata_b;
  assign sum     = {1'b0, low_val} + (CostW + 1)'(cost_q);
  always_comb begin
    if (s1_low_q) begin
      cand = CostW'(cost_q);
    end else if (sum > {1'b0, Unreachable}) begin
      cand = Unreachable;
    end else begin
      cand = sum[CostW-1:0];
    end
  end
  assign upd_we = s1_valid_q && (cand < rdata_a);

  always_comb begin
    raddr_a = cnt_q;
    raddr_b = cnt_q - AddrW'(gain_q);
    if (state_q == ST_IDLE) begin
      raddr_a = AddrW'(query_index_i);
    end
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = (cnt_q == '0) ? '0 : Unreachable;
    end else begin
      we    = upd_we;
      waddr = s1_t_q;
      wdata = cand;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    top_d      = top_q;
    cost_d     = cost_q;
    gain_d     = gain_q;
    qry_oor_d  = qry_oor_q;
    s1_valid_d = 1'b0;
    s1_t_d     = cnt_q;
    s1_low_d   = 32'(cnt_q) <= 32'(gain_q);
    fwd_d      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_ADD: begin
              cost_d = item_cost_i;
              gain_d = item_gain_i;
              top_d  = top_calc;
              cnt_d  = AddrW'(1);
              if ((item_gain_i != '0) && (top_calc != '0)) begin
                state_d = ST_ADD;
              end
            end
            OP_QUERY: begin
              qry_oor_d = 32'(query_index_i) >= TableDepth;
              state_d   = ST_QUERY;
            end
            OP_CLEAR: begin
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cnt_d = cnt_q + AddrW'(1);
        if (32'(cnt_q) == TableDepth - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_ADD: begin
        s1_valid_d = 1'b1;
        // gain of one reads the entry being written in this cycle
        fwd_d = !s1_low_d && upd_we && (raddr_b == s1_t_q);
        if (cnt_q == top_q) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      ST_QUERY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      s1_valid_q   <= 1'b0;
      fwd_q        <= 1'b0;
      max_target_q <= TargetW'(1023);
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      s1_valid_q <= s1_valid_d;
      fwd_q      <= fwd_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_target_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    cost_q     <= cost_d;
    gain_q     <= gain_d;
    qry_oor_q  <= qry_oor_d;
    s1_t_q     <= s1_t_d;
    s1_low_q   <= s1_low_d;
    fwd_data_q <= cand;
  end

  assign min_cost_valid_o = (state_q == ST_QUERY);
  assign min_cost_o       = qry_oor_q ? Unreachable : rdata_a;

  ukmc_ram #(
    .Width (CostW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

endmodule

// ===== hdl/ukmc_ram.sv =====
// ----------------------------------------------------------------------------
// ukmc_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module ukmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== hdl/ukmc_checker.sv =====
// ----------------------------------------------------------------------------
// ukmc_checker
// port-level checks of the knapsack table, bound to the top level
// ----------------------------------------------------------------------------
`include "unbounded_knapsack_min_cost_macros.svh"

module ukmc_checker
  import ukmc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic [1:0]           opcode_i,
  input logic [CostW-1:0]     min_cost_o,
  input logic                 min_cost_valid_o
);

  logic qry_req;
  logic clr_req;

  assign qry_req = start && !busy && (opcode_i == OP_QUERY);
  assign clr_req = start && !busy && (opcode_i == OP_CLEAR);

  `UKMC_ASSERT(a_query_answers, qry_req |=> min_cost_valid_o, "query request got no result")
  `UKMC_ASSERT(a_result_from_query, min_cost_valid_o |-> $past(qry_req), "result without query")
  `UKMC_ASSERT(a_clear_busy, clr_req |=> busy, "clear did not raise busy")
  `UKMC_ASSERT_NEVER(a_cost_range, min_cost_valid_o && (min_cost_o > Unreachable), "cost out of range")

endmodule

bind unbounded_knapsack_min_cost ukmc_checker u_ukmc_checker (.*);
